>>> rtl/multilevel_priority_fifo_top_macros.svh
// assertion macros for the multilevel priority fifo checker
// no dependencies; included by files that carry assertions
`ifndef MULTILEVEL_PRIORITY_FIFO_TOP_MACROS_SVH
`define MULTILEVEL_PRIORITY_FIFO_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define MLPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define MLPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mlpf_pkg.sv
// shared types and constants for the multilevel priority fifo
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mlpf_pkg;

    localparam int LEVELS_DEF      = 8;
    localparam int CAPACITY_DEF    = 64;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int HANDLE_W = 16;
    localparam int LEVEL_W  = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] LEVEL_COUNT_RST = 4'd8;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_BADLEVEL = 2'd3
    } t_status;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic ins;
        logic pop;
    } t_dp_cmd;

endpackage

>>> rtl/mlpf_ctrl.sv
// request sequencer for the multilevel priority fifo
// depends on mlpf_pkg
`timescale 1ns / 1ps

module mlpf_ctrl import mlpf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_req_type,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_POP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_ins, n_ins;
    logic   r_pop, n_pop;
    logic   load;

    assign load = i_start && !r_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (load) begin
                    n_state = (i_req_type == REQ_POP) ? S_POP : S_INSERT;
                end
            end
            S_INSERT: n_state = S_IDLE;
            S_POP:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
        n_ins  = (n_state == S_INSERT);
        n_pop  = (n_state == S_POP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_ins   <= 1'b0;
            r_pop   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_ins   <= n_ins;
            r_pop   <= n_pop;
        end
    end

    assign o_busy    = r_busy;
    assign o_cmd.load = load;
    assign o_cmd.ins  = r_ins;
    assign o_cmd.pop  = r_pop;

endmodule

>>> rtl/mlpf_datapath.sv
// linked entry store, per-level queues, free list and result register
// depends on mlpf_pkg
`timescale 1ns / 1ps

module mlpf_datapath import mlpf_pkg::*; #(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic                i_req_type,
    input  logic [LEVEL_W-1:0]  i_level,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic [LEVEL_W-1:0]  o_level_out
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int LVL_W  = $clog2(LEVELS);

    // entry store
    logic [HANDLE_BITS-1:0] handle_mem [CAPACITY];
    logic [ADDR_W-1:0]      link_mem   [CAPACITY];

    logic [CFG_W-1:0]       r_level_count;
    logic [ADDR_W-1:0]      r_head [LEVELS];
    logic [ADDR_W-1:0]      r_tail [LEVELS];
    logic [OCC_W-1:0]       r_occ  [LEVELS];
    logic [ADDR_W-1:0]      r_free_head;
    logic [OCC_W-1:0]       r_free_avail;
    logic [OCC_W-1:0]       r_fresh;

    // latched request
    logic [LEVEL_W-1:0]     r_level;
    logic [HANDLE_BITS-1:0] r_handle;
    logic                   r_pop_found;
    logic [LVL_W-1:0]       r_pop_lvl;
    logic [ADDR_W-1:0]      r_pop_slot;
    logic [HANDLE_BITS-1:0] r_handle_rd;
    logic [ADDR_W-1:0]      r_link_rd;

    // result register
    logic                   r_done;
    t_status                r_status;
    logic [HANDLE_W-1:0]    r_handle_out;
    logic [LEVEL_W-1:0]     r_level_out;

    logic                   pop_found;
    logic [LVL_W-1:0]       pop_idx;
    logic [ADDR_W-1:0]      rd_addr;
    logic [LVL_W-1:0]       lvl_idx;
    logic                   bad_level;
    logic                   use_free;
    logic                   full;
    logic [ADDR_W-1:0]      slot;
    logic                   ins_ok;
    logic                   pop_ok;
    logic                   pop_more;
    logic                   link_we;
    logic [ADDR_W-1:0]      link_waddr;
    logic [ADDR_W-1:0]      link_wdata;

    // lowest non-empty level
    always_comb begin
        pop_found = 1'b0;
        pop_idx   = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_occ[l] != '0) begin
                pop_found = 1'b1;
                pop_idx   = LVL_W'(l);
            end
        end
    end

    assign rd_addr = (i_req_type == REQ_POP) ? r_head[pop_idx] : r_free_head;

    assign lvl_idx   = LVL_W'(r_level);
    assign bad_level = ({1'b0, r_level} >= r_level_count) || (int'(r_level) >= LEVELS);
    assign use_free  = (r_free_avail != '0);
    assign full      = !use_free && (r_fresh == OCC_W'(CAPACITY));
    assign slot      = use_free ? r_free_head : ADDR_W'(r_fresh);
    assign ins_ok    = i_cmd.ins && !bad_level && !full;
    assign pop_ok    = i_cmd.pop && r_pop_found;
    assign pop_more  = (r_occ[r_pop_lvl] > OCC_W'(1));

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_pop_slot;
        link_wdata = r_free_head;
        if (pop_ok) begin
            link_we = 1'b1;
        end else if (ins_ok && (r_occ[lvl_idx] != '0)) begin
            link_we    = 1'b1;
            link_waddr = r_tail[lvl_idx];
            link_wdata = slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins_ok) begin
            handle_mem[slot] <= r_handle;
        end
        if (i_cmd.load) begin
            r_handle_rd <= handle_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (i_cmd.load) begin
            r_link_rd <= link_mem[rd_addr];
        end
    end

    // head and tail pointers, request latch and result payload
    always_ff @(posedge i_clk) begin
        if (ins_ok) begin
            if (r_occ[lvl_idx] == '0) begin
                r_head[lvl_idx] <= slot;
            end
            r_tail[lvl_idx] <= slot;
        end
        if (pop_ok && pop_more) begin
            r_head[r_pop_lvl] <= r_link_rd;
        end
        if (i_cmd.load) begin
            r_level     <= i_level;
            r_handle    <= HANDLE_BITS'(i_handle);
            r_pop_found <= pop_found;
            r_pop_lvl   <= pop_idx;
            r_pop_slot  <= r_head[pop_idx];
        end
        if (i_cmd.ins) begin
            r_handle_out <= '0;
            r_level_out  <= r_level;
            if (bad_level) begin
                r_status <= ST_BADLEVEL;
            end else if (full) begin
                r_status <= ST_FULL;
            end else begin
                r_status <= ST_OK;
            end
        end else if (i_cmd.pop) begin
            if (r_pop_found) begin
                r_status     <= ST_OK;
                r_handle_out <= HANDLE_W'(r_handle_rd);
                r_level_out  <= LEVEL_W'(r_pop_lvl);
            end else begin
                r_status     <= ST_EMPTY;
                r_handle_out <= '0;
                r_level_out  <= '0;
            end
        end
    end

    // counts, free list and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= LEVEL_COUNT_RST;
            for (int l = 0; l < LEVELS; l++) begin
                r_occ[l] <= '0;
            end
            r_free_head  <= '0;
            r_free_avail <= '0;
            r_fresh      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_done <= i_cmd.ins || i_cmd.pop;
            if (i_cfg_we) begin
                r_level_count <= i_cfg_wdata;
            end
            if (ins_ok) begin
                r_occ[lvl_idx] <= r_occ[lvl_idx] + OCC_W'(1);
                if (use_free) begin
                    r_free_head  <= r_link_rd;
                    r_free_avail <= r_free_avail - OCC_W'(1);
                end else begin
                    r_fresh <= r_fresh + OCC_W'(1);
                end
            end
            if (pop_ok) begin
                r_occ[r_pop_lvl] <= r_occ[r_pop_lvl] - OCC_W'(1);
                r_free_head      <= r_pop_slot;
                r_free_avail     <= r_free_avail + OCC_W'(1);
            end
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_handle_out = r_handle_out;
    assign o_level_out  = r_level_out;

endmodule

>>> rtl/multilevel_priority_fifo_top.sv
// top level of the multilevel priority fifo
// depends on mlpf_pkg, mlpf_ctrl and mlpf_datapath
`timescale 1ns / 1ps

// Multilevel priority FIFO. Task handles wait in one FIFO per priority level
// and level 0 is served first. A request is taken at a rising edge where
// start is high and busy is low; req_type 0 appends i_handle at the tail of
// level i_level, req_type 1 removes the oldest handle of the lowest-numbered
// non-empty level. Every request gives exactly one result, shown on the o_
// result ports for a single cycle while o_done is high; the receiver cannot
// stall it, so it must take the transfer in that cycle. Each request keeps
// busy high through its execute state after the accepting edge and its
// result appears in the cycle after that, so a new request can be taken
// while the previous result is still on show. The execute state is needed
// because the entry store's read of the head entry or of the free-list link
// is registered and lands in the cycle after acceptance. i_cfg_we writes the
// level count; it is to be written only while the block is idle.

module multilevel_priority_fifo_top import mlpf_pkg::*; #(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request transfer
    input  logic                start,
    output logic                busy,
    input  logic                i_req_type,
    input  logic [LEVEL_W-1:0]  i_level,
    input  logic [HANDLE_W-1:0] i_handle,
    // level count register
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    // result transfer, one cycle wide
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic [LEVEL_W-1:0]  o_level_out
);

    t_dp_cmd cmd;

    // sequencer: idle, then one execute state per request
    mlpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    // entry store, queue pointers, free list and result register
    mlpf_datapath #(
        .LEVELS      (LEVELS),
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_req_type),
        .i_level      (i_level),
        .i_handle     (i_handle),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_level_out  (o_level_out)
    );

endmodule

>>> rtl/mlpf_checker.sv
// port-level checks for the multilevel priority fifo, bound to the top level
// depends on mlpf_pkg and multilevel_priority_fifo_top_macros.svh
`timescale 1ns / 1ps
`include "multilevel_priority_fifo_top_macros.svh"

module mlpf_checker import mlpf_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                i_busy,
    input logic                i_done,
    input logic [STATUS_W-1:0] i_status,
    input logic [HANDLE_W-1:0] i_handle_out,
    input logic [LEVEL_W-1:0]  i_level_out
);

    // an accepted request executes next cycle with no result yet
    `MLPF_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_start && !i_busy, i_busy && !i_done, "accepted request did not start executing")

    // execution ends in a result in the next cycle, with busy low again
    `MLPF_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, i_busy, i_done && !i_busy, "execution did not end in a result")

    // a result is only shown while idle
    `MLPF_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, i_done, !i_busy, "result shown while busy")

    // an empty pop returns nothing
    `MLPF_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_done && (i_status == ST_EMPTY), (i_handle_out == '0) && (i_level_out == '0), "empty pop carried data")

    // rejected inserts carry no handle
    `MLPF_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, i_done && ((i_status == ST_FULL) || (i_status == ST_BADLEVEL)), i_handle_out == '0, "rejected insert carried a handle")

endmodule

bind multilevel_priority_fifo_top mlpf_checker u_mlpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (start),
    .i_busy       (busy),
    .i_done       (o_done),
    .i_status     (o_status),
    .i_handle_out (o_handle_out),
    .i_level_out  (o_level_out)
);

>>> sim/multilevel_priority_fifo_top_test.sv
// self-checking testbench for the multilevel priority fifo top level
// depends on mlpf_pkg and multilevel_priority_fifo_top from rtl
`timescale 1ns / 1ps

module multilevel_priority_fifo_top_test;
    import mlpf_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int REQUEST_GOAL = 1350;

    // one entry of the stimulus list: a request transfer or a level count write
    typedef struct packed {
        logic                is_cfg;
        logic [CFG_W-1:0]    cfg_value;
        logic                req_type;
        logic [LEVEL_W-1:0]  level;
        logic [HANDLE_W-1:0] handle;
        logic [4:0]          gap_max;
    } t_job;

    // what the block should report for one request
    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [LEVEL_W-1:0]  level;
    } t_outcome;

    // a handle waiting in the queue, tagged with its level
    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [HANDLE_W-1:0] handle;
    } t_waiting;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_req_type = REQ_INSERT;
    logic [LEVEL_W-1:0]  i_level = '0;
    logic [HANDLE_W-1:0] i_handle = '0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata = '0;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [LEVEL_W-1:0]  o_level_out;

    t_job       job_q[$];
    t_outcome   outcome_q[$];
    t_waiting   waiting[$];
    t_job       cur_job;
    logic [CFG_W-1:0] level_limit = LEVEL_COUNT_RST;

    int   idle_left = 0;
    int   settle = 0;
    int   quiet = 0;
    int   mismatches = 0;
    logic took;
    logic next_start;
    logic next_we;

    multilevel_priority_fifo_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_level      (i_level),
        .i_handle     (i_handle),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_level_out  (o_level_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor: one flat list of waiting handles in arrival order; a pop takes
    // the first entry of the lowest level, which is the oldest of that level
    function automatic t_outcome serve_request(t_job job);
        t_outcome res;
        int       pick;
        res.status = ST_OK;
        res.handle = '0;
        res.level  = job.level;
        if (job.req_type == REQ_INSERT) begin
            // level check comes ahead of the capacity check
            if (job.level >= level_limit || int'(job.level) >= LEVELS_DEF) begin
                res.status = ST_BADLEVEL;
            end else if (waiting.size() >= CAPACITY_DEF) begin
                res.status = ST_FULL;
            end else begin
                waiting.push_back('{level: job.level, handle: job.handle});
            end
        end else begin
            pick = -1;
            foreach (waiting[i]) begin
                if (pick < 0 || waiting[i].level < waiting[pick].level) pick = i;
            end
            if (pick < 0) begin
                res.status = ST_EMPTY;
                res.level  = '0;
            end else begin
                res.handle = waiting[pick].handle;
                res.level  = waiting[pick].level;
                waiting.delete(pick);
            end
        end
        return res;
    endfunction

    task automatic queue_request(input logic rt, input logic [LEVEL_W-1:0] lv,
                                 input logic [HANDLE_W-1:0] h, input logic [4:0] gm);
        t_job job;
        job           = '0;
        job.req_type  = rt;
        job.level     = lv;
        job.handle    = h;
        job.gap_max   = gm;
        job_q.push_back(job);
    endtask

    task automatic queue_config(input logic [CFG_W-1:0] value);
        t_job job;
        job           = '0;
        job.is_cfg    = 1'b1;
        job.cfg_value = value;
        job_q.push_back(job);
    endtask

    // driver: requests go out in list order; a level count write waits until
    // every outstanding result has come back and the block has settled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_cfg_we  <= 1'b0;
            idle_left = 0;
            settle    = 0;
        end else begin
            took       = start && !busy;
            next_start = start && !took;
            next_we    = 1'b0;
            // register takes the write at this edge
            if (i_cfg_we) level_limit = i_cfg_wdata;
            if (took) begin
                outcome_q.push_back(serve_request(cur_job));
                idle_left = $urandom_range(0, cur_job.gap_max);
            end
            settle = (outcome_q.size() == 0) ? settle + 1 : 0;
            if (!next_start) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (job_q.size() != 0) begin
                    if (job_q[0].is_cfg) begin
                        if (settle >= 3 && !busy) begin
                            next_we = 1'b1;
                            i_cfg_wdata <= job_q[0].cfg_value;
                            void'(job_q.pop_front());
                        end
                    end else begin
                        // keep start high straight through when there is no gap
                        cur_job    = job_q.pop_front();
                        next_start = 1'b1;
                        i_req_type <= cur_job.req_type;
                        i_level    <= cur_job.level;
                        i_handle   <= cur_job.handle;
                    end
                end
            end
            start    <= next_start;
            i_cfg_we <= next_we;
        end
    end

    // monitor: every done strobe is a result transfer, checked against the oldest
    // outstanding prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $error("result transfer with nothing outstanding: status %0d handle %0h",
                       o_status, o_handle_out);
                mismatches++;
            end else begin
                if (o_status !== outcome_q[0].status) begin
                    $error("status: expected %0d, got %0d", outcome_q[0].status, o_status);
                    mismatches++;
                end
                if (o_handle_out !== outcome_q[0].handle) begin
                    $error("handle_out: expected %0h, got %0h",
                           outcome_q[0].handle, o_handle_out);
                    mismatches++;
                end
                if (o_level_out !== outcome_q[0].level) begin
                    $error("level_out: expected %0d, got %0d", outcome_q[0].level, o_level_out);
                    mismatches++;
                end
                void'(outcome_q.pop_front());
            end
        end
    end

    // watchdog on cycles without any transfer or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int made;
        int lc;
        int ins_pct;
        int len;
        int phase;
        int top_level;
        logic [4:0] gm;
        logic [LEVEL_W-1:0] lv;

        // directed part, level count at its reset value
        queue_request(REQ_POP, 3'd5, 16'hBEEF, 5'd3);          // pop on empty queue
        queue_request(REQ_INSERT, 3'd0, 16'h0000, 5'd0);
        queue_request(REQ_INSERT, 3'd7, 16'hFFFF, 5'd1);
        queue_request(REQ_INSERT, 3'd3, 16'h5A5A, 5'd0);
        queue_request(REQ_INSERT, 3'd0, 16'hA5A5, 5'd2);
        queue_request(REQ_POP, 3'd0, 16'h0000, 5'd0);          // level 0 in arrival order
        queue_request(REQ_POP, 3'd0, 16'h0000, 5'd1);
        queue_request(REQ_POP, 3'd0, 16'h0000, 5'd0);
        queue_request(REQ_POP, 3'd0, 16'h0000, 5'd3);
        queue_request(REQ_POP, 3'd0, 16'hFFFF, 5'd0);          // drained again
        // register zero rejects every level
        queue_config(4'd0);
        queue_request(REQ_INSERT, 3'd0, 16'hFFFF, 5'd0);
        queue_request(REQ_INSERT, 3'd7, 16'h1234, 5'd2);
        queue_request(REQ_POP, 3'd0, 16'h0000, 5'd0);
        // register above the number of levels
        queue_config(4'd15);
        queue_request(REQ_INSERT, 3'd7, 16'h8001, 5'd1);
        // count lowered below a level that still holds a handle
        queue_config(4'd2);
        queue_request(REQ_INSERT, 3'd1, 16'h7FFE, 5'd0);
        queue_request(REQ_INSERT, 3'd2, 16'h0001, 5'd0);
        queue_request(REQ_INSERT, 3'd7, 16'hFFFE, 5'd2);
        queue_request(REQ_POP, 3'd0, 16'h0000, 5'd0);
        queue_request(REQ_POP, 3'd0, 16'h0000, 5'd1);
        queue_request(REQ_POP, 3'd0, 16'h0000, 5'd0);
        made = 20;

        // random phases, each under its own level count and insert mix; the
        // early phases force the extremes and a fill up to capacity
        phase = 0;
        while (made < REQUEST_GOAL) begin
            case (phase)
                0: lc = 8;
                1: lc = 1;
                2: lc = 15;
                3: lc = 0;
                4: lc = 4;
                default: lc = $urandom_range(0, 15);
            endcase
            queue_config(lc[CFG_W-1:0]);
            case ($urandom_range(0, 3))
                0: ins_pct = 25;
                1: ins_pct = 50;
                2: ins_pct = 75;
                default: ins_pct = 95;
            endcase
            if (phase < 2) ins_pct = 95;
            case ($urandom_range(0, 3))
                0: gm = 5'd0;
                1: gm = 5'd2;
                default: gm = 5'd16;
            endcase
            len = (lc == 0) ? $urandom_range(10, 25) : $urandom_range(40, 160);
            if (phase < 2) len = 120;
            top_level = (lc > LEVELS_DEF) ? LEVELS_DEF : lc;
            for (int n = 0; n < len && made < REQUEST_GOAL; n++) begin
                if ($urandom_range(0, 99) < ins_pct) begin
                    // mostly legal levels, the rest anywhere in the field
                    if (top_level > 0 && $urandom_range(0, 99) < 85)
                        lv = LEVEL_W'($urandom_range(0, top_level - 1));
                    else
                        lv = LEVEL_W'($urandom_range(0, 7));
                    queue_request(REQ_INSERT, lv, HANDLE_W'($urandom_range(0, 65535)),
                                  gm);
                end else begin
                    // pop with junk in the ignored fields
                    queue_request(REQ_POP, LEVEL_W'($urandom_range(0, 7)),
                                  HANDLE_W'($urandom_range(0, 65535)), gm);
                end
                made++;
            end
            phase++;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || start || outcome_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/mlpf_pkg.sv
rtl/mlpf_ctrl.sv
rtl/mlpf_datapath.sv
rtl/multilevel_priority_fifo_top.sv
rtl/mlpf_checker.sv
sim/multilevel_priority_fifo_top_test.sv
